// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define BLK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BLK_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/blk_pkg.sv =====
`timescale 1ns / 1ps

package blk_pkg;

   localparam int unsigned WordW = 64;

   localparam logic [63:0] Mask32 = 64'h0000_0000_ffff_ffff;

   // Mode register codes
   localparam logic [1:0] MODE_224 = 2'd0;
   localparam logic [1:0] MODE_256 = 2'd1;
   localparam logic [1:0] MODE_384 = 2'd2;
   localparam logic [1:0] MODE_512 = 2'd3;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_SALT_0 = 3'd1;
   localparam logic [2:0] REG_SALT_3 = 3'd4;

   // Index of the final round
   localparam logic [3:0] LastRound32 = 4'd13;
   localparam logic [3:0] LastRound64 = 4'd15;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [3:0][63:0]  salt;
   } cfg_type;

   localparam logic [5:0] Rot32 [4] = '{6'd16, 6'd12, 6'd8, 6'd7};
   localparam logic [5:0] Rot64 [4] = '{6'd32, 6'd25, 6'd16, 6'd11};

   localparam logic [31:0] K32 [16] = '{
      32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
      32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
      32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
      32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917};

   localparam logic [63:0] K64 [16] = '{
      64'h243f6a8885a308d3, 64'h13198a2e03707344, 64'ha4093822299f31d0,
      64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
      64'hc0ac29b7c97c50dd, 64'h3f84d5b5b5470917, 64'h9216d5d98979fb1b,
      64'hd1310ba698dfb5ac, 64'h2ffd72dbd01adfb7, 64'hb8e1afed6a267e96,
      64'hba7c9045f12c7f99, 64'h24a19947b3916cf7, 64'h0801f2e2858efc16,
      64'h636920d871574e69};

   localparam logic [63:0] Iv [4][8] = '{
      '{64'hc1059ed8, 64'h367cd507, 64'h3070dd17, 64'hf70e5939,
        64'hffc00b31, 64'h68581511, 64'h64f98fa7, 64'hbefa4fa4},
      '{64'h6a09e667, 64'hbb67ae85, 64'h3c6ef372, 64'ha54ff53a,
        64'h510e527f, 64'h9b05688c, 64'h1f83d9ab, 64'h5be0cd19},
      '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
      '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179}};

   localparam logic [3:0] Sigma [10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}};

   // Permutation row for a round (rounds wrap after ten)
   function automatic logic [3:0] sigma_row(input logic [3:0] round);
      sigma_row = (round >= 4'd10) ? round - 4'd10 : round;
   endfunction

   // Round constant, zero-extended in 32-bit modes
   function automatic logic [63:0] const_word(input logic wide, input logic [3:0] idx);
      const_word = wide ? K64[idx] : {32'd0, K32[idx]};
   endfunction

endpackage

// ===== rtl/blk_gunit.sv =====
`timescale 1ns / 1ps

// Quarter step of G: x = p + q + z, y = rotr(y ^ x) by the phase's amount.
module blk_gunit (
   input  logic        wide,
   input  logic [1:0]  phase,
   input  logic [63:0] p,
   input  logic [63:0] q,
   input  logic [63:0] z,
   input  logic [63:0] y,
   output logic [63:0] x_out,
   output logic [63:0] y_out
);

   logic [63:0] sum;
   logic [63:0] t;
   logic [31:0] t32;

   // Add, trimmed to the word size
   assign sum   = p + q + z;
   assign x_out = wide ? sum : (sum & blk_pkg::Mask32);
   assign t     = y ^ x_out;
   assign t32   = t[31:0];

   // Rotate by the fixed amount of this phase
   always_comb begin
      if (wide) begin
         unique case (phase)
            2'd0:    y_out = {t[31:0], t[63:32]};
            2'd1:    y_out = {t[24:0], t[63:25]};
            2'd2:    y_out = {t[15:0], t[63:16]};
            default: y_out = {t[10:0], t[63:11]};
         endcase
      end else begin
         unique case (phase)
            2'd0:    y_out = {32'd0, t32[15:0], t32[31:16]};
            2'd1:    y_out = {32'd0, t32[11:0], t32[31:12]};
            2'd2:    y_out = {32'd0, t32[7:0], t32[31:8]};
            default: y_out = {32'd0, t32[6:0], t32[31:7]};
         endcase
      end
   end

endmodule

// ===== rtl/blk_core.sv =====
`timescale 1ns / 1ps

module blk_core (
   input  logic             clock,
   input  logic             reset,
   input  blk_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [63:0]      in_msg,
   input  logic             in_first,
   input  logic [63:0]      in_counter,
   input  logic             in_no_ctr,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [63:0]      out_word,
   output logic [2:0]       out_index,
   output logic             out_last
);

   blk_pkg::state_type state_ff, state_in;
   logic [3:0]  word_cnt_ff, word_cnt_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  g_ff, g_in;
   logic [3:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic [63:0] chain_ff [8];
   logic [63:0] chain_in [8];
   logic [63:0] chain_eff [8];
   logic [63:0] v_ff [16];
   logic [63:0] v_in [16];
   logic [63:0] v_upd [16];
   logic [63:0] msg_mem [16];
   logic [63:0] mdata_ff;
   logic [3:0]  rd_addr;

   logic        accept;
   logic        wide;
   logic [63:0] mask;
   logic [3:0]  rsel, rsel_nx;
   logic [3:0]  round_nx;
   logic [2:0]  g_nx;
   logic [3:0]  s0, s1, s0_nx;
   logic [63:0] mk;
   logic [1:0]  shift [4];
   logic [63:0] gp, gq, gz, gy, gx_out, gy_out;
   logic [3:0]  last_round;

   assign accept     = in_valid && in_ready;
   assign wide       = cfg.mode[1];
   assign mask       = wide ? '1 : blk_pkg::Mask32;
   assign last_round = wide ? blk_pkg::LastRound64 : blk_pkg::LastRound32;

   // Message schedule lookups for this G and the next
   assign rsel     = blk_pkg::sigma_row(round_ff);
   assign g_nx     = g_ff + 3'd1;
   assign round_nx = (g_ff == 3'd7) ? round_ff + 4'd1 : round_ff;
   assign rsel_nx  = blk_pkg::sigma_row(round_nx);
   assign s0       = blk_pkg::Sigma[rsel][{g_ff, 1'b0}];
   assign s1       = blk_pkg::Sigma[rsel][{g_ff, 1'b1}];
   assign s0_nx    = blk_pkg::Sigma[rsel_nx][{g_nx, 1'b0}];

   // Message word xor constant for the add steps
   assign mk = (mdata_ff ^ blk_pkg::const_word(wide, phase_ff[1] ? s0 : s1)) & mask;

   // Operands: even phases update a and d, odd phases c and b
   always_comb begin
      if (!phase_ff[0]) begin
         gp = v_ff[0];
         gq = v_ff[4];
         gz = mk;
         gy = v_ff[12];
      end else begin
         gp = v_ff[8];
         gq = v_ff[12];
         gz = '0;
         gy = v_ff[4];
      end
   end

   blk_gunit u_gunit (
      .wide  (wide),
      .phase (phase_ff),
      .p     (gp),
      .q     (gq),
      .z     (gz),
      .y     (gy),
      .x_out (gx_out),
      .y_out (gy_out)
   );

   // Read address set in the cycle before the add step that needs it
   always_comb begin
      rd_addr = s1;
      if (state_ff == blk_pkg::ST_LOAD) begin
         rd_addr = blk_pkg::Sigma[0][0];
      end else if (phase_ff == 2'd3) begin
         rd_addr = s0_nx;
      end
   end

   // Row shifts after each G: columns move by one, diagonals set up and undone
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         if (g_ff == 3'd3) begin
            shift[r] = 2'(r + 1);
         end else if (g_ff == 3'd7) begin
            shift[r] = 2'(1 - r);
         end else begin
            shift[r] = 2'd1;
         end
      end
   end

   // Chain value seen by this transfer, with the IV load applied
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_eff[i] = in_first ? blk_pkg::Iv[cfg.mode][i] : chain_ff[i];
      end
   end

   // Work vector after the current quarter step
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         v_upd[i] = v_ff[i];
      end
      if (!phase_ff[0]) begin
         v_upd[0]  = gx_out;
         v_upd[12] = gy_out;
      end else begin
         v_upd[8] = gx_out;
         v_upd[4] = gy_out;
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      word_cnt_in = word_cnt_ff;
      phase_in    = phase_ff;
      g_in        = g_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i];
      end
      for (int i = 0; i < 16; i++) begin
         v_in[i] = v_ff[i];
      end

      unique case (state_ff)
         blk_pkg::ST_FILL: begin
            in_ready = 1'b1;
            if (accept) begin
               if (in_first) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = chain_eff[i];
                  end
               end
               word_cnt_in = word_cnt_ff + 4'd1;
               if (word_cnt_ff == 4'd15) begin
                  // Build the work vector from chain, constants, salt, counter
                  for (int i = 0; i < 8; i++) begin
                     v_in[i]     = chain_eff[i] & mask;
                     v_in[i + 8] = blk_pkg::const_word(wide, 4'(i));
                  end
                  for (int i = 0; i < 4; i++) begin
                     v_in[i + 8] = v_in[i + 8] ^ (cfg.salt[i] & mask);
                  end
                  if (!in_no_ctr) begin
                     if (wide) begin
                        v_in[12] = v_in[12] ^ in_counter;
                        v_in[13] = v_in[13] ^ in_counter;
                     end else begin
                        v_in[12] = v_in[12] ^ {32'd0, in_counter[31:0]};
                        v_in[13] = v_in[13] ^ {32'd0, in_counter[31:0]};
                        v_in[14] = v_in[14] ^ {32'd0, in_counter[63:32]};
                        v_in[15] = v_in[15] ^ {32'd0, in_counter[63:32]};
                     end
                  end
                  phase_in = 2'd0;
                  g_in     = 3'd0;
                  round_in = 4'd0;
                  state_in = blk_pkg::ST_LOAD;
               end
            end
         end
         blk_pkg::ST_LOAD: begin
            state_in = blk_pkg::ST_ROUND;
         end
         blk_pkg::ST_ROUND: begin
            phase_in = phase_ff + 2'd1;
            for (int i = 0; i < 16; i++) begin
               v_in[i] = v_upd[i];
            end
            if (phase_ff == 2'd3) begin
               for (int r = 0; r < 4; r++) begin
                  for (int j = 0; j < 4; j++) begin
                     v_in[4 * r + j] = v_upd[{2'(r), 2'(2'(j) + shift[r])}];
                  end
               end
               g_in     = g_nx;
               round_in = round_nx;
               if (g_ff == 3'd7 && round_ff == last_round) begin
                  state_in = blk_pkg::ST_FOLD;
               end
            end
         end
         blk_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = (chain_ff[i] ^ cfg.salt[i % 4] ^ v_ff[i] ^ v_ff[i + 8]) & mask;
            end
            out_idx_in = 3'd0;
            state_in   = blk_pkg::ST_EMIT;
         end
         blk_pkg::ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  state_in = blk_pkg::ST_FILL;
               end
            end
         end
         default: begin
            state_in = blk_pkg::ST_FILL;
         end
      endcase
   end

   assign out_word  = chain_ff[out_idx_ff];
   assign out_index = out_idx_ff;
   assign out_last  = (out_idx_ff == 3'd7);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= blk_pkg::ST_FILL;
         word_cnt_ff <= '0;
         phase_ff    <= '0;
         g_ff        <= '0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         phase_ff    <= phase_in;
         g_ff        <= g_in;
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // Work vector
   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

   // Message buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (accept) begin
         msg_mem[word_cnt_ff] <= in_msg;
      end
      mdata_ff <= msg_mem[rd_addr];
   end

endmodule

// ===== rtl/blake_compression.sv =====
`timescale 1ns / 1ps

// BLAKE compression engine for BLAKE-224/256/384/512. Message words are taken one per cycle on
// req_; after the sixteenth word the block stops accepting and runs the rounds on a single
// shared quarter-G unit, one quarter step per cycle, for 14 rounds on 32-bit words and 16
// rounds on 64-bit words. A load state primes the message buffer read before the rounds and a
// fold state folds the result into the chain after them, then the eight chain words leave on
// rsp_, index 7 marked by tlast. The chain is loaded from the IV of the current mode on any
// word with first_block set, and starts at zero after reset. Configuration (index 0 mode, 1 to
// 4 salt words) is to be written only while idle; the block itself does not enforce this.
module blake_compression (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // msg_word [63:0], bit_counter [127:64]
   input  logic [1:0]   req_tuser,  // first_block [0], no_counter [1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // chain_word [63:0], chain_index [66:64], zero [71:67]
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   blk_pkg::cfg_type cfg_ff, cfg_in;
   logic [63:0] chain_word;
   logic [2:0]  chain_index;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == blk_pkg::REG_MODE) begin
            cfg_in.mode = csr_data[1:0];
         end else if (csr_index >= blk_pkg::REG_SALT_0 && csr_index <= blk_pkg::REG_SALT_3) begin
            cfg_in.salt[2'(csr_index - blk_pkg::REG_SALT_0)] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= blk_pkg::MODE_256;
         cfg_ff.salt <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   blk_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_msg     (req_tdata[63:0]),
      .in_first   (req_tuser[0]),
      .in_counter (req_tdata[127:64]),
      .in_no_ctr  (req_tuser[1]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (chain_word),
      .out_index  (chain_index),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, chain_index, chain_word};

endmodule

// ===== rtl/blk_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module blk_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic         rsp_tlast,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [2:0]   csr_index,
   input logic [63:0]  csr_data
);

   // No intake while results are on offer
   `BLK_ASSERT(a_no_overlap, !(req_tready && rsp_tvalid), "input ready while emitting")

   // A stalled result holds
   `BLK_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed under stall")

   // tlast marks chain word seven
   `BLK_ASSERT(a_last_idx, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[66:64] == 3'd7)), "tlast off index seven")

   // Burst ends after the last transfer
   `BLK_ASSERT(a_burst_end, rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready, "no return to intake")

   // Nothing on offer just after reset
   `BLK_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result after reset")

endmodule

bind blake_compression blk_checker u_blk_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [63:0] msg_word;
      logic        first_block;
      logic [63:0] bit_counter;
      logic        no_counter;
   } word_item_type;

   typedef struct {
      logic [63:0] chain_word;
      logic [2:0]  chain_index;
      logic        last_word;
   } chain_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   // Shadow state of the engine
   logic [1:0]  hash_mode;
   logic [63:0] salt_word [4];
   logic [63:0] chain_state [8];
   logic [63:0] msg_buffer [16];
   logic [63:0] work_vec [16];
   int          word_count;

   word_item_type  pending_words [$];
   chain_item_type expected_chain [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  hold_off = 0;
   bit  stim_done = 1'b0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   blake_compression i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Note the transfers made at this edge for the falling-edge processes
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
   end

   function automatic logic [63:0] rot_right(logic [63:0] x, int n, bit wide);
      logic [31:0] lo;
      lo = x[31:0];
      if (wide) return (x >> n) | (x << (64 - n));
      return {32'd0, (lo >> n) | (lo << (32 - n))};
   endfunction

   function automatic logic [63:0] round_const(bit wide, int idx);
      return wide ? blk_pkg::K64[idx] : {32'd0, blk_pkg::K32[idx]};
   endfunction

   // One G mix on four words of the work vector
   task automatic g_mix(int r, int a, int b, int c, int d, int i, bit wide);
      logic [63:0] m, va, vb, vc, vd;
      int s0, s1;
      int r0, r1, r2, r3;
      m = wide ? ~64'd0 : blk_pkg::Mask32;
      r0 = wide ? 32 : 16; r1 = wide ? 25 : 12; r2 = wide ? 16 : 8; r3 = wide ? 11 : 7;
      s0 = blk_pkg::Sigma[r % 10][i];
      s1 = blk_pkg::Sigma[r % 10][i + 1];
      va = work_vec[a]; vb = work_vec[b]; vc = work_vec[c]; vd = work_vec[d];
      va = (va + vb + ((msg_buffer[s0] ^ round_const(wide, s1)) & m)) & m;
      vd = rot_right(vd ^ va, r0, wide);
      vc = (vc + vd) & m;
      vb = rot_right(vb ^ vc, r1, wide);
      va = (va + vb + ((msg_buffer[s1] ^ round_const(wide, s0)) & m)) & m;
      vd = rot_right(vd ^ va, r2, wide);
      vc = (vc + vd) & m;
      vb = rot_right(vb ^ vc, r3, wide);
      work_vec[a] = va; work_vec[b] = vb; work_vec[c] = vc; work_vec[d] = vd;
   endtask

   task automatic compress_block(logic [63:0] counter, logic skip_counter);
      bit wide;
      logic [63:0] m;
      int rounds;
      wide = hash_mode >= blk_pkg::MODE_384;
      m = wide ? ~64'd0 : blk_pkg::Mask32;
      rounds = wide ? 16 : 14;
      for (int i = 0; i < 16; i++) msg_buffer[i] &= m;
      for (int i = 0; i < 8; i++) begin
         work_vec[i] = chain_state[i] & m;
         work_vec[i + 8] = round_const(wide, i);
         if (i < 4) work_vec[i + 8] ^= salt_word[i] & m;
      end
      if (!skip_counter) begin
         if (wide) begin
            work_vec[12] ^= counter;
            work_vec[13] ^= counter;
         end else begin
            work_vec[12] ^= counter & blk_pkg::Mask32;
            work_vec[13] ^= counter & blk_pkg::Mask32;
            work_vec[14] ^= counter >> 32;
            work_vec[15] ^= counter >> 32;
         end
      end
      for (int r = 0; r < rounds; r++) begin
         g_mix(r, 0, 4, 8, 12, 0, wide);
         g_mix(r, 1, 5, 9, 13, 2, wide);
         g_mix(r, 2, 6, 10, 14, 4, wide);
         g_mix(r, 3, 7, 11, 15, 6, wide);
         g_mix(r, 0, 5, 10, 15, 8, wide);
         g_mix(r, 1, 6, 11, 12, 10, wide);
         g_mix(r, 2, 7, 8, 13, 12, wide);
         g_mix(r, 3, 4, 9, 14, 14, wide);
      end
      for (int i = 0; i < 8; i++)
         chain_state[i] = (chain_state[i] ^ salt_word[i & 3] ^ work_vec[i] ^ work_vec[i + 8]) & m;
   endtask

   // Advance the shadow engine by one accepted word
   task automatic predict_word(word_item_type w);
      chain_item_type c;
      if (w.first_block)
         for (int i = 0; i < 8; i++) chain_state[i] = blk_pkg::Iv[hash_mode][i];
      msg_buffer[word_count] = w.msg_word;
      if (word_count < 15) begin
         word_count++;
         return;
      end
      word_count = 0;
      compress_block(w.bit_counter, w.no_counter);
      for (int i = 0; i < 8; i++) begin
         c.chain_word = chain_state[i];
         c.chain_index = i[2:0];
         c.last_word = (i == 7);
         expected_chain.push_back(c);
      end
   endtask

   // Driver: offer pending words with random gaps
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            predict_word(pending_words.pop_front());
            req_gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_words[0].bit_counter, pending_words[0].msg_word};
            req_tuser  <= {pending_words[0].no_counter, pending_words[0].first_block};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with a long hold-off when asked
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (rsp_taken) begin
            rsp_gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) rsp_gap = 0;
            rsp_tready <= (rsp_gap == 0);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= (rsp_gap == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: compare each chain word transfer with the oldest expectation
   always @(posedge clock) begin
      chain_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chain.size() == 0) begin
            $error("unexpected chain word %h", rsp_tdata[63:0]);
            error_count++;
         end else begin
            e = expected_chain.pop_front();
            if (rsp_tdata[63:0] !== e.chain_word) begin
               $error("chain_word expected %h got %h", e.chain_word, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tdata[66:64] !== e.chain_index) begin
               $error("chain_index expected %0d got %0d", e.chain_index, rsp_tdata[66:64]);
               error_count++;
            end
            if (rsp_tlast !== e.last_word) begin
               $error("last_word expected %0d got %0d", e.last_word, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Write one register over the CSR channel
   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == blk_pkg::REG_MODE) hash_mode = value[1:0];
      else salt_word[idx - blk_pkg::REG_SALT_0] = value;
   endtask

   // Wait until the engine has drained every expected word
   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || expected_chain.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_word(logic [63:0] msg, logic first, logic [63:0] cnt, logic nocnt);
      word_item_type w;
      w.msg_word = msg; w.first_block = first; w.bit_counter = cnt; w.no_counter = nocnt;
      pending_words.push_back(w);
   endtask

   // Queue one sixteen-word block with random content
   task automatic queue_block(bit first);
      for (int i = 0; i < 16; i++)
         queue_word(rand64(), (i == 0) ? first : ($urandom_range(0, 30) == 0),
                    rand64(), $urandom_range(0, 4) == 0);
   endtask

   initial begin
      hash_mode = blk_pkg::MODE_256;
      for (int i = 0; i < 4; i++) salt_word[i] = '0;
      for (int i = 0; i < 8; i++) chain_state[i] = '0;
      for (int i = 0; i < 16; i++) begin
         msg_buffer[i] = '0;
         work_vec[i] = '0;
      end
      word_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Chaining before any first block, reset settings
      queue_block(1'b0);
      drain();

      // Extremes of fields, first block flag mid-block, all modes
      for (int md = 0; md < 4; md++) begin
         write_csr(blk_pkg::REG_MODE, 64'(md));
         for (int s = 0; s < 4; s++)
            write_csr(3'(blk_pkg::REG_SALT_0 + s),
                      (md == 1) ? '0 : (md == 2) ? ~64'd0 : rand64());
         for (int i = 0; i < 16; i++)
            queue_word((i & 1) ? ~64'd0 : 64'd0, (i == 0) || (i == 7),
                       (md & 1) ? ~64'd0 : 64'd0, (md == 2));
         drain();
      end

      // Long receiver hold-off while two blocks are offered
      write_csr(blk_pkg::REG_MODE, 64'(blk_pkg::MODE_256));
      hold_off = 1200;
      queue_block(1'b1);
      queue_block(1'b0);
      drain();

      // Random messages across settings, mode changed mid-message once
      for (int ph = 0; ph < 2; ph++) begin
         write_csr(blk_pkg::REG_MODE, 64'($urandom_range(0, 3)));
         for (int s = 0; s < 4; s++) write_csr(3'(blk_pkg::REG_SALT_0 + s), rand64());
         queue_block(1'b1);
         if (ph == 1) begin
            drain();
            write_csr(blk_pkg::REG_MODE, 64'($urandom_range(0, 3)));
         end
         queue_block(1'b0);
         drain();
      end
      // Noise words with random flags on every word
      for (int i = 0; i < 16; i++)
         queue_word(rand64(), 1'($urandom_range(0, 1)), rand64(), 1'($urandom_range(0, 1)));
      drain();
      repeat (10) @(posedge clock);

      if (error_count == 0 && expected_chain.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
